// ----- hdl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and codes for the bitmap store engine: item structs, request
// codes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int POS_W = 12;
    localparam int LEN_W = 13;
    localparam int ANS_W = 13;
    localparam int REQ_W = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    localparam logic [REQ_W-1:0] REQ_TEST   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ZRUN   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FILL1  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FILL0  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE  = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] bit_position;
    } req_item_t;

    typedef struct packed {
        logic [ANS_W-1:0] answer;
        logic             position_ok;
    } rsp_item_t;

    typedef struct packed {
        logic capture;
        logic start;
        logic walk;
        logic sweep;
        logic sweep_ones;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             reject;
        logic             walk_last;
        logic             sweep_last;
        logic             out_free;
    } dp_stat_t;

endpackage

// ----- hdl/bse_datapath.sv -----
// ----------------------------------------------------------------------------
// bse_datapath
// Bitmap word memory, length register, request registers, word walk logic
// (bit test and update, zero run, ones count), fill sweep and result register.
// ----------------------------------------------------------------------------
module bse_datapath #(
    parameter int MAX_BITS  = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bse_pkg::req_item_t           req,
    input  logic                         cfg_valid,
    input  logic [bse_pkg::LEN_W-1:0]    cfg_data,
    input  bse_pkg::dp_cmd_t             cmd,
    output bse_pkg::dp_stat_t            stat,
    input  logic                         rsp_stall,
    output logic                         rsp_valid,
    output bse_pkg::rsp_item_t           rsp
);
    import bse_pkg::*;

    localparam int WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OW    = $clog2(WORD_BITS);
    localparam int SPAN  = WORDS * WORD_BITS;
    localparam int SPW   = $clog2(SPAN + 1);
    localparam int CW    = ((SPW > LEN_W) ? SPW : LEN_W) + 1;
    localparam int PW    = $clog2(WORD_BITS + 1);
    localparam int SH    = 24;
    localparam int RW    = SH - 2;
    localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PRW   = POS_W + RW;
    localparam int QW    = PRW - SH;

    localparam logic [CW-1:0] MAX_C   = CW'(MAX_BITS);
    localparam logic [CW-1:0] W_C     = CW'(WORD_BITS);
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [AW-1:0] LAST_A  = AW'(WORDS - 1);
    localparam logic [AW-1:0] ONE_A   = AW'(1);

    logic [WORD_BITS-1:0] bitmap_mem [WORDS];

    logic [LEN_W-1:0]     bit_length_reg;
    logic [AW-1:0]        sweep_reg;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_reg;

    logic [REQ_W-1:0]     type_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 ok_reg;
    logic [QW-1:0]        q_reg;
    logic [OW-1:0]        off_reg;
    logic [CW-1:0]        base_reg;
    logic [AW-1:0]        nxt_reg;
    logic [AW-1:0]        proc_reg;
    logic                 first_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ANS_W-1:0]     acc_reg;
    logic [ANS_W-1:0]     acc_next;

    logic [CW-1:0]        len_cfg;
    logic                 positional;
    logic                 in_range;
    logic [PRW-1:0]       q_prod;
    logic [CW-1:0]        q_base;
    logic [OW-1:0]        off_start;
    logic [AW-1:0]        q_addr;
    logic [AW-1:0]        rd_addr;

    logic [CW-1:0]        len_c;
    logic [CW-1:0]        base_end;
    logic                 covers;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] zr_word;
    logic [WORD_BITS-1:0] zr_iso;
    logic [OW-1:0]        tz;
    logic [CW-1:0]        found;
    logic                 zr_hit;
    logic [CW-1:0]        zr_end;
    logic [CW-1:0]        cnt_rem;
    logic [PW-1:0]        pop;
    logic [WORD_BITS-1:0] wr_word;
    logic                 walk_last;
    logic                 is_update;

    // request decode at capture
    always_comb
    begin
        len_cfg    = (CW'(bit_length_reg) > MAX_C) ? MAX_C : CW'(bit_length_reg);
        positional = req.req_type inside {REQ_TEST, REQ_SET, REQ_CLEAR, REQ_ZRUN};
        in_range   = CW'(req.bit_position) < len_cfg;
        q_prod     = PRW'(req.bit_position) * PRW'(RECIP_C);
    end

    // word index and bit offset
    always_comb
    begin
        q_base    = CW'(q_reg) * W_C;
        off_start = OW'(CW'(pos_reg) - q_base);
        q_addr    = AW'(q_reg);
        rd_addr   = cmd.start ? ((type_reg == REQ_COUNT) ? '0 : q_addr) : nxt_reg;
    end

    // word walk
    always_comb
    begin
        len_c    = CW'(len_reg);
        base_end = base_reg + W_C;
        covers   = base_end >= len_c;
        cnt_rem  = len_c - base_reg;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            low_mask[k] = first_reg && (OW'(k) < off_reg);
        end
        zr_word = rd_data_reg & ~low_mask;
        zr_iso  = zr_word & (~zr_word + 1'b1);
        zr_hit  = |zr_word;
        tz      = '0;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (zr_iso[k])
            begin
                tz = tz | OW'(k);
            end
        end
        found  = base_reg + CW'(tz);
        zr_end = (zr_hit && (found < len_c)) ? found : len_c;
        pop    = '0;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            pop = pop + PW'(rd_data_reg[k] && (CW'(k) < cnt_rem));
        end
        for (int k = 0; k < WORD_BITS; k++)
        begin
            wr_word[k] = (OW'(k) == off_reg) ? (type_reg == REQ_SET) : rd_data_reg[k];
        end
        is_update = (type_reg == REQ_SET) || (type_reg == REQ_CLEAR);
        case (type_reg)
            REQ_ZRUN:  walk_last = zr_hit || covers;
            REQ_COUNT: walk_last = covers;
            default:   walk_last = 1'b1;
        endcase
        case (type_reg)
            REQ_TEST:  acc_next = ANS_W'(rd_data_reg[off_reg]);
            REQ_ZRUN:  acc_next = ANS_W'(zr_end - CW'(pos_reg));
            REQ_COUNT: acc_next = acc_reg + ANS_W'(pop);
            default:   acc_next = acc_reg;
        endcase
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            bitmap_mem[sweep_reg] <= cmd.sweep_ones ? '1 : '0;
        end
        else if (cmd.walk && is_update)
        begin
            bitmap_mem[proc_reg] <= wr_word;
        end
        if (cmd.start || cmd.walk)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_length_reg <= LEN_RESET;
            sweep_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bit_length_reg <= cfg_data;
            end
            if (cmd.sweep)
            begin
                sweep_reg <= (sweep_reg == LAST_A) ? '0 : sweep_reg + ONE_A;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= req.req_type;
            pos_reg  <= req.bit_position;
            len_reg  <= LEN_W'(len_cfg);
            ok_reg   <= !positional || in_range;
            q_reg    <= q_prod[PRW-1:SH];
            acc_reg  <= '0;
        end
        if (cmd.start)
        begin
            first_reg <= 1'b1;
            if (type_reg == REQ_COUNT)
            begin
                base_reg <= '0;
                proc_reg <= '0;
                nxt_reg  <= ONE_A;
            end
            else
            begin
                base_reg <= q_base;
                off_reg  <= off_start;
                proc_reg <= q_addr;
                nxt_reg  <= q_addr + ONE_A;
            end
        end
        if (cmd.walk)
        begin
            first_reg <= 1'b0;
            base_reg  <= base_end;
            proc_reg  <= nxt_reg;
            nxt_reg   <= nxt_reg + ONE_A;
            if (walk_last || (type_reg == REQ_COUNT))
            begin
                acc_reg <= acc_next;
            end
        end
        if (cmd.finish)
        begin
            rsp_reg.answer      <= acc_reg;
            rsp_reg.position_ok <= ok_reg;
        end
    end

    always_comb
    begin
        stat.req_type   = type_reg;
        stat.reject     = !ok_reg || (type_reg == REQ_SPARE);
        stat.walk_last  = walk_last;
        stat.sweep_last = sweep_reg == LAST_A;
        stat.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hdl/bse_ctrl.sv -----
// ----------------------------------------------------------------------------
// bse_ctrl
// Request sequencer: clearing pass after reset, request decode, word walk,
// fill sweep and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module bse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bse_pkg::dp_stat_t stat,
    output bse_pkg::dp_cmd_t  cmd
);
    import bse_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_WALK   = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.reject)
                begin
                    state_next = S_DONE;
                end
                else if (stat.req_type inside {REQ_FILL1, REQ_FILL0})
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_ones = stat.req_type == REQ_FILL1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/bitmap_store_engine_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_store_engine_top
// Bitmap store with bit test, set and clear, zero-run length, ones count
// and whole-store fill, one result item per request item.
// ----------------------------------------------------------------------------
// Request channel req_valid / req_stall / req, response channel rsp_valid /
// rsp_stall / rsp; an item moves when valid is high and stall is low.
// cfg_valid / cfg_ready / cfg_data writes bit_length (reset 4096); write it
// only while no request is in flight. cfg_ready is always high.
// One request is worked at a time; the bitmap memory gives one word per
// cycle, which sets the walk rate. Words visited per request item:
//   test, set, clear: one word; flagged or unused codes: none
//   zero run: from the start word to the first one or the end of bit_length
//   ones count: ceil(bit_length / WORD_BITS), at least one word
//   fill ones / fill zeros: ceil(MAX_BITS / WORD_BITS), every word
// After reset a clearing pass writes every word to zero, one word a cycle;
// req_stall stays high until it ends.
// The result waits in an output register while rsp_stall is high; the next
// request is still taken, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module bitmap_store_engine_top #(
    parameter int MAX_BITS  = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  bse_pkg::req_item_t        req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output bse_pkg::rsp_item_t        rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bse_pkg::LEN_W-1:0] cfg_data
);
    import bse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bse_datapath #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- hdl/bse_checker.sv -----
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks for the bitmap store engine, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input bse_pkg::rsp_item_t rsp
);
    import bse_pkg::*;

    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while an item is in flight");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.position_ok |-> rsp.answer == '0)
        else $error("flagged item carries a non-zero answer");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response item changed");

    a_rsp_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(!rsp_stall))
        else $error("response item dropped without handshake");

endmodule

bind bitmap_store_engine_top bse_checker u_bse_checker (.*);
